// File: src/rmap_pkg.sv
// shared constants and types for the region map block
// no dependencies
package rmap_pkg;
    localparam int MaxRegions = 128;
    localparam int AddrBits   = 48;
    localparam int IdxBits    = $clog2(MaxRegions);
    localparam int CntBits    = $clog2(MaxRegions + 1);
    typedef logic [AddrBits-1:0] t_addr;
    typedef logic [IdxBits-1:0]  t_idx;
    typedef logic [CntBits-1:0]  t_cnt;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_AVAIL  = 2'd2;
    localparam logic [1:0] OP_TOTAL  = 2'd3;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;
endpackage

// File: src/region_map_add_remove.sv
// region map top level: sorted disjoint region table in main and scratch memories
// depends on rmap_pkg
// an add widens its range in one or two grow passes; an empty or inverted add
// or remove goes straight to the result
// one operation at a time: each table has one read port, and the passes read
// one table entry per cycle while the copy pass does not hold the read stream
// the result sits in an output register; a new beat is taken once it is taken
// reset (synchronous, active low) empties the table; no clearing pass
module region_map_add_remove (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [47:0] i_range_base,
    input  logic [47:0] i_range_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_region_count,
    output logic [47:0] o_byte_total
);
    // fsm codes
    localparam logic [2:0] S_IDLE  = 3'd0; // wait for a beat
    localparam logic [2:0] S_GROW  = 3'd1; // add: widen range over table until stable
    localparam logic [2:0] S_SCAN  = 3'd2; // read pass: full checks, queries
    localparam logic [2:0] S_COPY  = 3'd3; // build new table in scratch memory
    localparam logic [2:0] S_BACK  = 3'd4; // copy scratch back to main table
    localparam logic [2:0] S_DONE  = 3'd5; // load output register

    // main table and scratch table, one read and one write port each
    rmap_pkg::t_addr m_start [rmap_pkg::MaxRegions];
    rmap_pkg::t_addr m_stop  [rmap_pkg::MaxRegions];
    rmap_pkg::t_addr t_start_m [rmap_pkg::MaxRegions];
    rmap_pkg::t_addr t_stop_m  [rmap_pkg::MaxRegions];

    logic [2:0]          r_state;
    logic [1:0]          r_op;
    rmap_pkg::t_addr     r_lo, r_hi;
    rmap_pkg::t_cnt      r_used;
    rmap_pkg::t_cnt      r_rd;      // read address counter (issues)
    rmap_pkg::t_cnt      r_k;       // write count into scratch
    logic                r_dv;      // read data valid this cycle
    rmap_pkg::t_idx      r_didx;    // index of read data
    rmap_pkg::t_addr     r_ds, r_de;
    logic                r_changed, r_placed, r_merged, r_split;
    logic                r_found;
    logic                r_pend;    // second split half waiting
    rmap_pkg::t_addr     r_pend_s, r_pend_e;
    rmap_pkg::t_addr     r_total;
    logic [1:0]          r_status;

    // scratch write port
    logic            w_en;
    rmap_pkg::t_addr w_s, w_e;
    rmap_pkg::t_idx  w_idx;
    // back-copy read
    rmap_pkg::t_addr r_bs, r_be;

    wire rmap_pkg::t_idx rd_idx = r_rd[rmap_pkg::IdxBits-1:0];
    wire issue_done = (r_rd >= r_used);
    wire last_data  = r_dv && ({1'b0, r_didx} == r_used - 1'b1);
    wire full       = (r_used == rmap_pkg::t_cnt'(rmap_pkg::MaxRegions));

    // overlap or touch for add
    wire touch = (r_hi >= r_ds) && (r_lo <= r_de);
    // remove classes
    wire rm_split = (r_ds < r_lo) && (r_hi < r_de);
    wire rm_del   = (r_lo <= r_ds) && (r_de <= r_hi);
    wire rm_left  = (r_lo <= r_ds) && (r_hi > r_ds);
    wire rm_right = (r_lo < r_de) && (r_hi >= r_de);

    // table reads, registered
    always_ff @(posedge i_clk) begin
        r_ds <= m_start[rd_idx];
        r_de <= m_stop[rd_idx];
        r_bs <= t_start_m[rd_idx];
        r_be <= t_stop_m[rd_idx];
        if (w_en) begin
            t_start_m[w_idx] <= w_s;
            t_stop_m[w_idx]  <= w_e;
        end
        if (r_state == S_BACK && r_dv) begin
            m_start[r_didx] <= r_bs;
            m_stop[r_didx]  <= r_be;
        end
    end

    // scratch write selection during copy pass
    always_comb begin
        w_en  = 1'b0;
        w_s   = r_ds;
        w_e   = r_de;
        w_idx = r_k[rmap_pkg::IdxBits-1:0];
        if (r_state == S_COPY) begin
            if (r_pend) begin
                w_en = 1'b1; w_s = r_pend_s; w_e = r_pend_e;
            end else if (r_dv) begin
                if (r_op == rmap_pkg::OP_ADD) begin
                    if (!touch) begin
                        w_en = 1'b1;
                        if (!r_placed && r_ds >= r_lo) begin
                            w_s = r_lo; w_e = r_hi;
                        end
                    end
                end else if (rm_split) begin
                    w_en = 1'b1; w_e = r_lo;
                end else if (rm_del) begin
                    w_en = 1'b0;
                end else if (rm_left) begin
                    w_en = 1'b1; w_s = r_hi;
                end else if (rm_right) begin
                    w_en = 1'b1; w_e = r_lo;
                end else begin
                    w_en = 1'b1;
                end
            end else if (r_op == rmap_pkg::OP_ADD && !r_placed && issue_done) begin
                w_en = 1'b1; w_s = r_lo; w_e = r_hi;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            o_valid <= 1'b0;
            r_dv    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op      <= i_operation;
                        r_lo      <= i_range_base;
                        r_hi      <= i_range_end;
                        r_rd      <= '0;
                        r_dv      <= 1'b0;
                        r_k       <= '0;
                        r_changed <= 1'b0;
                        r_placed  <= 1'b0;
                        r_merged  <= 1'b0;
                        r_split   <= 1'b0;
                        r_found   <= 1'b0;
                        r_total   <= '0;
                        r_status  <= rmap_pkg::ST_OK;
                        if ((i_operation == rmap_pkg::OP_ADD ||
                             i_operation == rmap_pkg::OP_REMOVE) &&
                            i_range_end <= i_range_base)
                            r_state <= S_DONE;
                        else if (i_operation == rmap_pkg::OP_ADD)
                            r_state <= S_GROW;
                        else
                            r_state <= S_SCAN;
                    end
                end
                S_GROW: begin
                    // one pass per round; repeat while the range widened
                    if (r_used == '0) begin
                        r_state <= S_SCAN;
                    end else begin
                        if (!issue_done) r_rd <= r_rd + 1'b1;
                        r_dv   <= !issue_done;
                        r_didx <= rd_idx;
                        if (r_dv && touch) begin
                            if (r_ds < r_lo) begin r_lo <= r_ds; r_changed <= 1'b1; end
                            if (r_de > r_hi) begin r_hi <= r_de; r_changed <= 1'b1; end
                        end
                        if (last_data) begin
                            r_rd <= '0; r_dv <= 1'b0;
                            if (!(r_changed || (touch && (r_ds < r_lo || r_de > r_hi))))
                                r_state <= S_SCAN;
                            r_changed <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (!issue_done) r_rd <= r_rd + 1'b1;
                    r_dv   <= !issue_done;
                    r_didx <= rd_idx;
                    if (r_dv) begin
                        if (touch) r_merged <= 1'b1;
                        if (rm_split) r_split <= 1'b1;
                        // only a lookup answers with the bytes left in a region
                        if (r_op == rmap_pkg::OP_AVAIL && !r_found &&
                            r_ds <= r_lo && r_lo <= r_de) begin
                            r_found <= 1'b1;
                            r_total <= r_de - r_lo;
                        end
                        if (r_op == rmap_pkg::OP_TOTAL)
                            r_total <= r_total + (r_de - r_ds);
                    end
                    if (r_used == '0 || last_data) begin
                        r_rd <= '0; r_dv <= 1'b0;
                        case (r_op)
                            rmap_pkg::OP_ADD: begin
                                if (!(r_merged || (r_dv && touch)) && full) begin
                                    r_status <= rmap_pkg::ST_FULL; r_state <= S_DONE;
                                end else r_state <= S_COPY;
                            end
                            rmap_pkg::OP_REMOVE: begin
                                if ((r_split || (r_dv && rm_split)) && full) begin
                                    r_status <= rmap_pkg::ST_FULL; r_state <= S_DONE;
                                end else r_state <= S_COPY;
                            end
                            rmap_pkg::OP_AVAIL: begin
                                if (!(r_found || (r_dv && r_ds <= r_lo && r_lo <= r_de)))
                                    r_status <= rmap_pkg::ST_MISS;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_COPY: begin
                    // a split or a placed add writes two entries; hold the read stream for the second
                    if (w_en) r_k <= r_k + 1'b1;
                    if (r_pend) begin
                        r_pend <= 1'b0;
                    end else begin
                        if (!issue_done && !(r_dv && r_op == rmap_pkg::OP_REMOVE && rm_split))
                            r_rd <= r_rd + 1'b1;
                        r_dv   <= !issue_done && !(r_dv && r_op == rmap_pkg::OP_REMOVE
                                                   && rm_split);
                        r_didx <= rd_idx;
                        if (r_dv && r_op == rmap_pkg::OP_ADD && !touch && !r_placed
                            && r_ds >= r_lo) begin
                            r_placed <= 1'b1;
                            r_pend   <= 1'b1; r_pend_s <= r_ds; r_pend_e <= r_de;
                            r_rd <= r_rd; r_dv <= 1'b0;
                        end
                        if (r_dv && r_op == rmap_pkg::OP_REMOVE && rm_split) begin
                            r_pend <= 1'b1; r_pend_s <= r_hi; r_pend_e <= r_de;
                        end
                        if (!r_dv && issue_done) begin
                            if (r_op == rmap_pkg::OP_ADD && !r_placed) r_placed <= 1'b1;
                            r_used <= w_en ? r_k + 1'b1 : r_k;
                            r_rd   <= '0;
                            r_state <= S_BACK;
                        end
                    end
                end
                S_BACK: begin
                    if (!issue_done) r_rd <= r_rd + 1'b1;
                    r_dv   <= !issue_done;
                    r_didx <= rd_idx;
                    if (issue_done && !r_dv) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid) begin
                        o_valid  <= 1'b1;
                        o_status <= r_status;
                        o_region_count <= 8'(r_used);
                        o_byte_total <= 48'(r_total);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= rmap_pkg::t_cnt'(rmap_pkg::MaxRegions))
        else $error("region count beyond table");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    a_full_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rmap_pkg::ST_FULL) |-> full)
        else $error("full status with room left");
endmodule

// File: bench/region_map_checker.sv
// checker for the region map: watches both channels, keeps its own region table,
// predicts each result and compares it with the whole result beat; depends on rmap_pkg
module region_map_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [47:0] i_range_base,
    input  logic [47:0] i_range_end,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_region_count,
    input  logic [47:0] i_byte_total,
    output int          o_errors,
    output int          o_pending,
    output int          o_held
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  count;
        logic [47:0] total;
    } t_answer;

    rmap_pkg::t_addr span_lo [$];
    rmap_pkg::t_addr span_hi [$];
    t_answer         answers [$];

    function automatic bit joins(rmap_pkg::t_addr lo, rmap_pkg::t_addr hi, int i);
        return hi >= span_lo[i] && lo <= span_hi[i];
    endfunction

    function automatic logic [1:0] add_span(rmap_pkg::t_addr lo, rmap_pkg::t_addr hi);
        bit grew;
        int hits;
        int pos;
        if (hi <= lo) return rmap_pkg::ST_OK;
        grew = 1;
        while (grew) begin
            grew = 0;
            foreach (span_lo[i]) begin
                if (joins(lo, hi, i)) begin
                    if (span_lo[i] < lo) begin lo = span_lo[i]; grew = 1; end
                    if (span_hi[i] > hi) begin hi = span_hi[i]; grew = 1; end
                end
            end
        end
        hits = 0;
        foreach (span_lo[i]) if (joins(lo, hi, i)) hits++;
        if (hits == 0 && span_lo.size() >= rmap_pkg::MaxRegions) return rmap_pkg::ST_FULL;
        for (int i = span_lo.size() - 1; i >= 0; i--) begin
            if (joins(lo, hi, i)) begin
                span_lo.delete(i);
                span_hi.delete(i);
            end
        end
        pos = span_lo.size();
        foreach (span_lo[i]) begin
            if (span_lo[i] >= lo) begin pos = i; break; end
        end
        span_lo.insert(pos, lo);
        span_hi.insert(pos, hi);
        return rmap_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] remove_span(rmap_pkg::t_addr lo, rmap_pkg::t_addr hi);
        rmap_pkg::t_addr nlo [$];
        rmap_pkg::t_addr nhi [$];
        rmap_pkg::t_addr s;
        rmap_pkg::t_addr e;
        if (hi <= lo) return rmap_pkg::ST_OK;
        foreach (span_lo[i])
            if (span_lo[i] < lo && hi < span_hi[i] &&
                span_lo.size() >= rmap_pkg::MaxRegions)
                return rmap_pkg::ST_FULL;
        foreach (span_lo[i]) begin
            s = span_lo[i];
            e = span_hi[i];
            if (s < lo && hi < e) begin
                nlo = {nlo, s};  nhi = {nhi, lo};
                nlo = {nlo, hi}; nhi = {nhi, e};
            end else if (lo <= s && e <= hi) begin
            end else if (lo <= s && hi > s) begin
                nlo = {nlo, hi}; nhi = {nhi, e};
            end else if (lo < e && hi >= e) begin
                nlo = {nlo, s};  nhi = {nhi, lo};
            end else begin
                nlo = {nlo, s};  nhi = {nhi, e};
            end
        end
        span_lo = nlo;
        span_hi = nhi;
        return rmap_pkg::ST_OK;
    endfunction

    function automatic t_answer apply_beat(logic [1:0] op, rmap_pkg::t_addr a,
                                           rmap_pkg::t_addr b);
        t_answer r;
        r = '0;
        case (op)
            rmap_pkg::OP_ADD:    r.status = add_span(a, b);
            rmap_pkg::OP_REMOVE: r.status = remove_span(a, b);
            rmap_pkg::OP_AVAIL: begin
                r.status = rmap_pkg::ST_MISS;
                foreach (span_lo[i]) begin
                    if (span_lo[i] <= a && a <= span_hi[i]) begin
                        r.total  = span_hi[i] - a;
                        r.status = rmap_pkg::ST_OK;
                        break;
                    end
                end
            end
            default: foreach (span_lo[i]) r.total += span_hi[i] - span_lo[i];
        endcase
        r.count = 8'(span_lo.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
            o_held    <= 0;
            span_lo.delete();
            span_hi.delete();
            answers.delete();
        end else begin
            if (i_out_valid && i_ready) begin
                if (answers.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %0d %0d %0h",
                             $time, i_status, i_region_count, i_byte_total);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers.pop_front();
                    if (want !== {i_status, i_region_count, i_byte_total}) begin
                        $display("%0t: mismatch expected %0d %0d %0h actual %0d %0d %0h",
                                 $time, want.status, want.count, want.total,
                                 i_status, i_region_count, i_byte_total);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready)
                answers.insert(answers.size(),
                               apply_beat(i_operation, i_range_base, i_range_end));
            o_pending <= answers.size();
            o_held    <= span_lo.size();
        end
    end
endmodule

// File: bench/region_map_add_remove_tb.sv
// top of the region map testbench: clock, reset, stimulus and verdict
// depends on rmap_pkg, region_map_add_remove and region_map_checker
module region_map_add_remove_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_operation = rmap_pkg::OP_TOTAL;
    logic [47:0] i_range_base = '0;
    logic [47:0] i_range_end = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic [7:0]  o_region_count;
    logic [47:0] o_byte_total;
    int          errors;
    int          pending;
    int          held;
    bit          calm = 0;   // no idling on either side while set

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    region_map_add_remove dut (.*);

    region_map_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_operation,
        .i_range_base, .i_range_end, .i_out_valid(o_valid), .i_ready,
        .i_status(o_status), .i_region_count(o_region_count),
        .i_byte_total(o_byte_total),
        .o_errors(errors), .o_pending(pending), .o_held(held)
    );

    // result side stalls at random
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 14);
    end

    // one beat: optional gap with valid low, then hold valid until it is taken
    task automatic send(logic [1:0] op, logic [47:0] a, logic [47:0] b);
        while (!calm && $urandom_range(99) < 14) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid      <= 1;
        i_operation  <= op;
        i_range_base <= a;
        i_range_end  <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random address, mostly in a narrow window so ranges collide
    function automatic logic [47:0] pick_addr(int wide);
        if (wide) return 48'({$urandom, $urandom});
        return 48'(32'h1000 + $urandom_range(4095));
    endfunction

    initial begin
        logic [47:0] a;
        logic [47:0] b;
        logic [1:0]  op;
        int          wide;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table queries, extremes, inverted and empty ranges
        send(rmap_pkg::OP_TOTAL, '0, '0);
        send(rmap_pkg::OP_AVAIL, 48'h10, '0);
        send(rmap_pkg::OP_ADD, 48'h100, 48'h100);
        send(rmap_pkg::OP_ADD, 48'h200, 48'h100);
        send(rmap_pkg::OP_REMOVE, 48'h200, 48'h100);
        send(rmap_pkg::OP_ADD, '0, 48'hffff_ffff_ffff);
        send(rmap_pkg::OP_TOTAL, '0, '0);
        send(rmap_pkg::OP_AVAIL, 48'hffff_ffff_ffff, '0);
        send(rmap_pkg::OP_REMOVE, 48'h1000, 48'h2000);
        send(rmap_pkg::OP_REMOVE, '0, 48'h10);
        send(rmap_pkg::OP_REMOVE, 48'hffff_ffff_0000, 48'hffff_ffff_ffff);
        send(rmap_pkg::OP_AVAIL, 48'h1000, '0);
        send(rmap_pkg::OP_AVAIL, 48'h2000, '0);
        send(rmap_pkg::OP_AVAIL, 48'h1800, '0);
        send(rmap_pkg::OP_REMOVE, '0, 48'hffff_ffff_ffff);
        send(rmap_pkg::OP_ADD, 48'h10, 48'h20);
        send(rmap_pkg::OP_ADD, 48'h30, 48'h40);
        send(rmap_pkg::OP_ADD, 48'h20, 48'h30);   // touching on both sides
        send(rmap_pkg::OP_ADD, 48'h5, 48'h50);
        send(rmap_pkg::OP_TOTAL, '0, '0);

        // fill the table to its limit and push past it
        send(rmap_pkg::OP_REMOVE, '0, 48'hffff_ffff_ffff);
        for (int i = 0; i < rmap_pkg::MaxRegions; i++)
            send(rmap_pkg::OP_ADD, 48'(i * 16), 48'(i * 16 + 8));
        send(rmap_pkg::OP_ADD, 48'h10000, 48'h10008);     // full, refused
        send(rmap_pkg::OP_REMOVE, 48'h2, 48'h4);          // split in full table, refused
        send(rmap_pkg::OP_ADD, 48'h8, 48'h10);            // merge allowed when full
        send(rmap_pkg::OP_REMOVE, 48'h0, 48'h2);          // truncate allowed
        send(rmap_pkg::OP_TOTAL, '0, '0);

        // sender holds off until the block has drained
        i_valid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        send(rmap_pkg::OP_REMOVE, '0, 48'hffff_ffff_ffff);

        for (int n = 0; n < 900; n++) begin
            calm = (n >= 400 && n < 520);
            wide = ($urandom_range(9) == 0);
            a = pick_addr(wide);
            b = ($urandom_range(9) == 0) ? pick_addr(wide) : a + $urandom_range(64);
            case ($urandom_range(9))
                0, 1, 2, 3: op = rmap_pkg::OP_ADD;
                4, 5, 6:    op = rmap_pkg::OP_REMOVE;
                7, 8:       op = rmap_pkg::OP_AVAIL;
                default:    op = rmap_pkg::OP_TOTAL;
            endcase
            // keep the table from staying choked for long
            if (held > 100 && op == rmap_pkg::OP_ADD && $urandom_range(1))
                op = rmap_pkg::OP_REMOVE;
            if (wide && $urandom_range(1)) a = $urandom_range(1) ? '0 : 48'hffff_ffff_ffff;
            send(op, a, b);
        end
        calm = 0;
        i_valid <= 0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("region_map_add_remove test passed");
        else
            $display("region_map_add_remove test failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("region_map_add_remove test failed");
        $finish;
    end
endmodule

// File: region_map_add_remove.f
src/rmap_pkg.sv
src/region_map_add_remove.sv
bench/region_map_checker.sv
bench/region_map_add_remove_tb.sv
